// ----- rtl/core/gsv_pkg.sv -----
// shared types and constants of the gas spoilage verdict block
`default_nettype none

package gsv_pkg;

  // field widths
  localparam int GAS_W   = 16;
  localparam int TEMP_W  = 12;
  localparam int HUM_W   = 10;
  localparam int RUN_W   = 4;
  localparam int SCORE_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // one ring entry: temperature, air, alcohol from the top bit down
  localparam int WORD_W = TEMP_W + 2 * GAS_W;

  // gas thresholds in tenths of ppm
  localparam int ALC_T3 = 1500;
  localparam int ALC_T2 = 800;
  localparam int ALC_T1 = 300;
  localparam int AIR_T2 = 600;
  localparam int AIR_T1 = 200;

  // environment limits in tenths
  localparam int HUM_LIMIT   = 850;
  localparam int TEMP_LIMIT  = 250;
  localparam int DRIFT_LIMIT = 50;

  // score steps of the verdict map
  localparam int SCORE_ROTTEN  = 6;
  localparam int SCORE_SUSPECT = 4;
  localparam int SCORE_MONITOR = 2;

  localparam logic [RUN_W-1:0] RUN_MAX    = 4'd15;
  localparam logic [RUN_W-1:0] RISE_RESET = 4'd3;
  localparam logic [RUN_W-1:0] FALL_RESET = 4'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALC_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AIR_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_BASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_VALID = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_RUNS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_RUNS  = 3'd5;

  typedef enum logic [2:0] {
    VERD_UNCAL   = 3'd0,
    VERD_FRESH   = 3'd1,
    VERD_MONITOR = 3'd2,
    VERD_SUSPECT = 3'd3,
    VERD_ROTTEN  = 3'd4
  } verdict_t;

  // per-sample control traveling down the pipeline
  typedef struct packed {
    logic valid;
    logic hum_hi;
    logic temp_hi;
  } gsv_flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/gsv_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module gsv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the contents before a same-cycle write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/gsv_ring.sv -----
// sample window ring in ram with running window sums
`default_nettype none

module gsv_ring
  import gsv_pkg::*;
#(
  parameter int WINDOW = 5,
  localparam int SLW = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int SW  = GAS_W + $clog2(WINDOW + 1),
  localparam int STW = TEMP_W + $clog2(WINDOW + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     advance,
  input  wire gsv_flags_t               in_flags,
  input  wire logic        [GAS_W-1:0]  in_alc,
  input  wire logic        [GAS_W-1:0]  in_air,
  input  wire logic        [TEMP_W-1:0] in_temp,
  output gsv_flags_t                    sum_flags,
  output logic             [SW-1:0]     alc_sum,
  output logic             [SW-1:0]     air_sum,
  output logic signed      [STW-1:0]    temp_sum
);

  logic [SLW-1:0]    slot;
  logic              accept;

  // read stage registers
  logic              b_valid;
  logic              b_hum_hi;
  logic              b_temp_hi;
  logic [SLW-1:0]    b_slot;
  logic [WORD_W-1:0] b_word;
  logic              b_fwd;

  logic [WORD_W-1:0] last_wr;
  logic [WINDOW-1:0] entry_valid;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] old_word;

  logic        [GAS_W-1:0]  old_alc;
  logic        [GAS_W-1:0]  old_air;
  logic signed [TEMP_W-1:0] old_temp;
  logic        [GAS_W-1:0]  new_alc;
  logic        [GAS_W-1:0]  new_air;
  logic signed [TEMP_W-1:0] new_temp;

  logic        [SW-1:0]  alc_sum_next;
  logic        [SW-1:0]  air_sum_next;
  logic signed [STW-1:0] temp_sum_next;

  assign accept = advance && in_flags.valid;

  gsv_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (advance && b_valid),
    .waddr (b_slot),
    .wdata (b_word),
    .re    (accept),
    .raddr (slot),
    .rdata (rdata)
  );

  // old entry: forwarded when written the cycle it was read, zero if never written
  always_comb begin
    if (b_fwd) begin
      old_word = last_wr;
    end else if (entry_valid[b_slot]) begin
      old_word = rdata;
    end else begin
      old_word = '0;
    end
  end

  assign old_alc  = old_word[GAS_W-1:0];
  assign old_air  = old_word[2*GAS_W-1:GAS_W];
  assign old_temp = old_word[WORD_W-1:2*GAS_W];
  assign new_alc  = b_word[GAS_W-1:0];
  assign new_air  = b_word[2*GAS_W-1:GAS_W];
  assign new_temp = b_word[WORD_W-1:2*GAS_W];

  // running sums: add the new sample, drop the one it replaces
  always_comb begin
    alc_sum_next  = alc_sum + SW'(new_alc) - SW'(old_alc);
    air_sum_next  = air_sum + SW'(new_air) - SW'(old_air);
    temp_sum_next = temp_sum + STW'(new_temp) - STW'(old_temp);
  end

  // slot counter, stage control, entry valid bits and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      slot        <= '0;
      b_valid     <= 1'b0;
      sum_flags   <= '0;
      entry_valid <= '0;
      alc_sum     <= '0;
      air_sum     <= '0;
      temp_sum    <= '0;
    end else if (advance) begin
      b_valid   <= accept;
      sum_flags <= '{valid: b_valid, hum_hi: b_hum_hi, temp_hi: b_temp_hi};
      if (accept) begin
        slot <= (slot == SLW'(WINDOW - 1)) ? '0 : slot + 1'b1;
      end
      if (b_valid) begin
        entry_valid[b_slot] <= 1'b1;
        alc_sum             <= alc_sum_next;
        air_sum             <= air_sum_next;
        temp_sum            <= temp_sum_next;
      end
    end
  end

  // read stage payload and forwarding data
  always_ff @(posedge clk) begin
    if (accept) begin
      b_slot    <= slot;
      b_word    <= {in_temp, in_air, in_alc};
      b_hum_hi  <= in_flags.hum_hi;
      b_temp_hi <= in_flags.temp_hi;
      b_fwd     <= b_valid && (b_slot == slot);
    end
    if (advance && b_valid) begin
      last_wr <= b_word;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/gsv_judge.sv -----
// threshold scoring, verdict hysteresis and result register
`default_nettype none

module gsv_judge
  import gsv_pkg::*;
#(
  parameter int WINDOW = 5,
  localparam int SW  = GAS_W + $clog2(WINDOW + 1),
  localparam int STW = TEMP_W + $clog2(WINDOW + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     advance,
  input  wire gsv_flags_t               sum_flags,
  input  wire logic        [SW-1:0]     alc_sum,
  input  wire logic        [SW-1:0]     air_sum,
  input  wire logic signed [STW-1:0]    temp_sum,
  input  wire logic        [GAS_W-1:0]  alcohol_base,
  input  wire logic        [GAS_W-1:0]  air_base,
  input  wire logic signed [TEMP_W-1:0] temp_base,
  input  wire logic                     base_valid,
  input  wire logic        [RUN_W-1:0]  rise_runs,
  input  wire logic        [RUN_W-1:0]  fall_runs,
  output logic                          out_valid,
  output logic             [SCORE_W-1:0] score,
  output verdict_t                      verdict,
  output logic                          drift_warning
);

  localparam int TW  = SW + 1;
  localparam int TTW = STW + 1;

  localparam logic [TW-1:0] WIN_U  = TW'(WINDOW);
  localparam logic [TW-1:0] K_ALC3 = TW'(WINDOW * ALC_T3);
  localparam logic [TW-1:0] K_ALC2 = TW'(WINDOW * ALC_T2);
  localparam logic [TW-1:0] K_ALC1 = TW'(WINDOW * ALC_T1);
  localparam logic [TW-1:0] K_AIR2 = TW'(WINDOW * AIR_T2);
  localparam logic [TW-1:0] K_AIR1 = TW'(WINDOW * AIR_T1);
  localparam logic signed [TTW-1:0] WIN_S   = TTW'(WINDOW);
  localparam logic signed [TTW-1:0] K_DRIFT = TTW'(WINDOW * DRIFT_LIMIT);

  // thresholds on the window sums, refreshed from the baseline each cycle
  logic        [TW-1:0]  alc_base_x;
  logic        [TW-1:0]  air_base_x;
  logic signed [TTW-1:0] temp_base_x;
  logic        [TW-1:0]  thr_alc3, thr_alc2, thr_alc1;
  logic        [TW-1:0]  thr_air2, thr_air1;
  logic signed [TTW-1:0] thr_temp_hi, thr_temp_lo;

  logic        [TW-1:0]  alc_sum_x;
  logic        [TW-1:0]  air_sum_x;
  logic signed [TTW-1:0] temp_sum_x;

  logic [1:0]         alc_pts;
  logic [1:0]         air_pts;
  logic [SCORE_W-1:0] score_now;
  verdict_t           cand;
  logic               drift_now;

  verdict_t           held_verdict;
  verdict_t           held_next;
  logic [RUN_W-1:0]   run_count;
  logic [RUN_W-1:0]   run_next;
  logic [RUN_W-1:0]   run_inc;
  logic [RUN_W-1:0]   need;

  always_comb begin
    alc_base_x  = TW'(alcohol_base) * WIN_U;
    air_base_x  = TW'(air_base) * WIN_U;
    temp_base_x = TTW'(temp_base) * WIN_S;
  end

  always_ff @(posedge clk) begin
    thr_alc3    <= alc_base_x + K_ALC3;
    thr_alc2    <= alc_base_x + K_ALC2;
    thr_alc1    <= alc_base_x + K_ALC1;
    thr_air2    <= air_base_x + K_AIR2;
    thr_air1    <= air_base_x + K_AIR1;
    thr_temp_hi <= temp_base_x + K_DRIFT;
    thr_temp_lo <= temp_base_x - K_DRIFT;
  end

  assign alc_sum_x  = TW'(alc_sum);
  assign air_sum_x  = TW'(air_sum);
  assign temp_sum_x = TTW'(temp_sum);

  // tiered gas points plus the two environment points
  always_comb begin
    if (alc_sum_x > thr_alc3) begin
      alc_pts = 2'd3;
    end else if (alc_sum_x > thr_alc2) begin
      alc_pts = 2'd2;
    end else if (alc_sum_x > thr_alc1) begin
      alc_pts = 2'd1;
    end else begin
      alc_pts = 2'd0;
    end
    if (air_sum_x > thr_air2) begin
      air_pts = 2'd2;
    end else if (air_sum_x > thr_air1) begin
      air_pts = 2'd1;
    end else begin
      air_pts = 2'd0;
    end
    score_now = SCORE_W'(alc_pts) + SCORE_W'(air_pts)
              + SCORE_W'(sum_flags.hum_hi) + SCORE_W'(sum_flags.temp_hi);
    drift_now = (temp_sum_x > thr_temp_hi) || (temp_sum_x < thr_temp_lo);
  end

  // score to candidate verdict
  always_comb begin
    if (score_now >= SCORE_W'(SCORE_ROTTEN)) begin
      cand = VERD_ROTTEN;
    end else if (score_now >= SCORE_W'(SCORE_SUSPECT)) begin
      cand = VERD_SUSPECT;
    end else if (score_now >= SCORE_W'(SCORE_MONITOR)) begin
      cand = VERD_MONITOR;
    end else begin
      cand = VERD_FRESH;
    end
  end

  // hysteresis: a change lands once the run count reaches the needed runs
  always_comb begin
    run_inc   = (run_count < RUN_MAX) ? run_count + 1'b1 : RUN_MAX;
    need      = (cand > held_verdict) ? rise_runs : fall_runs;
    held_next = held_verdict;
    run_next  = run_inc;
    if ((cand != held_verdict) && (run_inc >= need)) begin
      held_next = cand;
      run_next  = '0;
    end
  end

  // hysteresis state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      held_verdict <= VERD_UNCAL;
      run_count    <= '0;
    end else if (advance) begin
      out_valid <= sum_flags.valid;
      if (sum_flags.valid && base_valid) begin
        held_verdict <= held_next;
        run_count    <= run_next;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance && sum_flags.valid) begin
      if (base_valid) begin
        score         <= score_now;
        verdict       <= held_next;
        drift_warning <= drift_now;
      end else begin
        score         <= '0;
        verdict       <= VERD_UNCAL;
        drift_warning <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/gas_spoilage_verdict_hysteresis.sv -----
// top level: spoilage score and verdict with hysteresis over a sample window
// a sample passes the ram read stage and the window sum registers before its result is registered
// throughput: one sample per cycle; the pipeline holds only while a result waits with m_tready low
// the window lives in one ram read and written once per sample, running sums update in one add
// reset: sums, slot and hysteresis clear; ring entries read as zero through per-entry
//   valid bits, so no clearing pass is needed and samples are taken right after reset
`default_nettype none

module gas_spoilage_verdict_hysteresis
  import gsv_pkg::*;
#(
  parameter int WINDOW = 5,
  localparam int SW  = GAS_W + $clog2(WINDOW + 1),
  localparam int STW = TEMP_W + $clog2(WINDOW + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // sample stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [55:0]           s_tdata,  // alc_reading, air_ppm, temperature, humidity
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [7:0]                 m_tdata,  // score, verdict, drift_warning
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic advance;

  logic        [GAS_W-1:0]  in_alc;
  logic        [GAS_W-1:0]  in_air;
  logic signed [TEMP_W-1:0] in_temp;
  logic        [HUM_W-1:0]  in_hum;
  gsv_flags_t               in_flags;
  gsv_flags_t               sum_flags;

  logic        [SW-1:0]  alc_sum;
  logic        [SW-1:0]  air_sum;
  logic signed [STW-1:0] temp_sum;

  logic        [GAS_W-1:0]  alcohol_base;
  logic        [GAS_W-1:0]  air_base;
  logic signed [TEMP_W-1:0] temp_base;
  logic                     base_valid;
  logic        [RUN_W-1:0]  rise_runs;
  logic        [RUN_W-1:0]  fall_runs;

  logic [SCORE_W-1:0] score;
  verdict_t           verdict;
  logic               drift_warning;

  // pipeline moves whenever the result register is free or drained
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;
  assign cfg_ready = 1'b1;

  // unpack sample fields
  assign in_alc  = s_tdata[15:0];
  assign in_air  = s_tdata[31:16];
  assign in_temp = s_tdata[43:32];
  assign in_hum  = s_tdata[53:44];

  // raw environment points
  always_comb begin
    in_flags.valid   = s_tvalid;
    in_flags.hum_hi  = in_hum > HUM_W'(HUM_LIMIT);
    in_flags.temp_hi = in_temp > TEMP_W'(TEMP_LIMIT);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alcohol_base <= '0;
      air_base     <= '0;
      temp_base    <= '0;
      base_valid   <= 1'b0;
      rise_runs    <= RISE_RESET;
      fall_runs    <= FALL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ALC_BASE:   alcohol_base <= cfg_data[GAS_W-1:0];
        CFG_AIR_BASE:   air_base     <= cfg_data[GAS_W-1:0];
        CFG_TEMP_BASE:  temp_base    <= cfg_data[TEMP_W-1:0];
        CFG_BASE_VALID: base_valid   <= cfg_data[0];
        CFG_RISE_RUNS:  rise_runs    <= cfg_data[RUN_W-1:0];
        CFG_FALL_RUNS:  fall_runs    <= cfg_data[RUN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gsv_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_flags  (in_flags),
    .in_alc    (in_alc),
    .in_air    (in_air),
    .in_temp   (in_temp),
    .sum_flags (sum_flags),
    .alc_sum   (alc_sum),
    .air_sum   (air_sum),
    .temp_sum  (temp_sum)
  );

  gsv_judge #(
    .WINDOW (WINDOW)
  ) u_judge (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .sum_flags     (sum_flags),
    .alc_sum       (alc_sum),
    .air_sum       (air_sum),
    .temp_sum      (temp_sum),
    .alcohol_base  (alcohol_base),
    .air_base      (air_base),
    .temp_base     (temp_base),
    .base_valid    (base_valid),
    .rise_runs     (rise_runs),
    .fall_runs     (fall_runs),
    .out_valid     (m_tvalid),
    .score         (score),
    .verdict       (verdict),
    .drift_warning (drift_warning)
  );

  // pack result fields
  assign m_tdata = {1'b0, drift_warning, verdict, score};

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// testbench of the gas spoilage verdict block: sample stream in, scored verdicts checked
module tb
  import gsv_pkg::*;
;

  localparam int WINDOW        = 5;
  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_LIMIT   = 50;
  localparam int GAS_MAX       = 65535;
  localparam int TEMP_MIN      = -400;
  localparam int TEMP_MAX      = 1250;
  localparam int HUM_MAX       = 1000;

  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // one sample as it sits on s_tdata, alcohol in the low bits
  typedef struct packed {
    logic [1:0]               pad;
    logic [HUM_W-1:0]         humidity;
    logic signed [TEMP_W-1:0] temperature;
    logic [GAS_W-1:0]         air;
    logic [GAS_W-1:0]         alcohol;
  } sample_t;

  // one result as it sits on m_tdata, score in the low bits
  typedef struct packed {
    logic               pad;
    logic               drift;
    verdict_t           verdict;
    logic [SCORE_W-1:0] score;
  } verdict_rec_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [55:0]           s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gas_spoilage_verdict_hysteresis dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // predictor state: sample windows, hysteresis and register copies
  logic [GAS_W-1:0]         alc_ring  [WINDOW] = '{default: '0};
  logic [GAS_W-1:0]         air_ring  [WINDOW] = '{default: '0};
  logic signed [TEMP_W-1:0] temp_ring [WINDOW] = '{default: '0};
  int                       slot = 0;
  verdict_t                 held = VERD_UNCAL;
  logic [RUN_W-1:0]         runs = '0;
  logic [GAS_W-1:0]         alc_base = '0;
  logic [GAS_W-1:0]         air_base = '0;
  logic signed [TEMP_W-1:0] temp_base = '0;
  logic                     base_on = 1'b0;
  logic [RUN_W-1:0]         rise_need = RISE_RESET;
  logic [RUN_W-1:0]         fall_need = FALL_RESET;

  verdict_rec_t pending_verdicts [$];
  int           mismatch_count = 0;
  logic         idle_on = 1'b1;
  int unsigned  hold_request = 0;
  logic         hold_active = 1'b0;
  int unsigned  stall_left = 0;
  int unsigned  cycle_count = 0;

  // score, verdict and drift flag that one sample should produce
  function automatic verdict_rec_t grade_sample(sample_t s);
    verdict_rec_t res;
    int sum_alc, sum_air, sum_temp, d_alc, d_air, d_temp, pts, i;
    verdict_t cand;
    logic [RUN_W-1:0] need;
    res = '0;
    sum_alc = 0;
    sum_air = 0;
    sum_temp = 0;
    pts = 0;
    alc_ring[slot] = s.alcohol;
    air_ring[slot] = s.air;
    temp_ring[slot] = s.temperature;
    slot = (slot == WINDOW - 1) ? 0 : slot + 1;
    // no baseline: window still fills, output all zero, hysteresis frozen
    if (!base_on) return res;
    for (i = 0; i < WINDOW; i++) begin
      sum_alc += int'(alc_ring[i]);
      sum_air += int'(air_ring[i]);
      sum_temp += int'(temp_ring[i]);
    end
    d_alc = sum_alc - WINDOW * int'(alc_base);
    d_air = sum_air - WINDOW * int'(air_base);
    d_temp = sum_temp - WINDOW * int'(temp_base);
    // tiered gas points, then raw environment points
    if (d_alc > WINDOW * ALC_T3) pts += 3;
    else if (d_alc > WINDOW * ALC_T2) pts += 2;
    else if (d_alc > WINDOW * ALC_T1) pts += 1;
    if (d_air > WINDOW * AIR_T2) pts += 2;
    else if (d_air > WINDOW * AIR_T1) pts += 1;
    if (int'(s.humidity) > HUM_LIMIT) pts += 1;
    if (int'(s.temperature) > TEMP_LIMIT) pts += 1;
    if (pts >= SCORE_ROTTEN) cand = VERD_ROTTEN;
    else if (pts >= SCORE_SUSPECT) cand = VERD_SUSPECT;
    else if (pts >= SCORE_MONITOR) cand = VERD_MONITOR;
    else cand = VERD_FRESH;
    // hysteresis: saturating run count, separate rise and fall needs
    if (runs != RUN_MAX) runs = runs + 1'b1;
    if (cand == held) begin
      res.verdict = cand;
    end else begin
      need = (cand > held) ? rise_need : fall_need;
      if (runs >= need) begin
        held = cand;
        runs = '0;
      end
      res.verdict = held;
    end
    res.score = pts[SCORE_W-1:0];
    res.drift = (d_temp > WINDOW * DRIFT_LIMIT) || (d_temp < -WINDOW * DRIFT_LIMIT);
    return res;
  endfunction

  function automatic int clamp_int(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int wobble(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic sample_t make_sample(int alc, int air, int temp, int hum);
    sample_t s;
    s = '0;
    s.alcohol = GAS_W'(alc);
    s.air = GAS_W'(air);
    s.temperature = TEMP_W'(temp);
    s.humidity = HUM_W'(hum);
    return s;
  endfunction

  // gas offset from baseline, often sitting exactly on a tier edge
  function automatic int tier_offset(int t1, int t2, int t3);
    case ($urandom_range(0, 8))
      0: return 0;
      1: return t1;
      2: return t1 + 1;
      3: return t2;
      4: return t2 + 1;
      5: return t3;
      6: return t3 + 1;
      7: return $urandom_range(0, 4000);
      default: return -int'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic int pick_gas_base();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return GAS_MAX;
      default: return $urandom_range(0, 30000);
    endcase
  endfunction

  function automatic int pick_temp_base();
    case ($urandom_range(0, 7))
      0: return TEMP_MIN;
      1: return TEMP_MAX;
      default: return int'($urandom_range(0, 500)) - 100;
    endcase
  endfunction

  function automatic int pick_runs();
    case ($urandom_range(0, 5))
      0: return 1;
      1: return 15;
      default: return $urandom_range(1, 15);
    endcase
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // offer one sample, keep tvalid high for the next one unless a gap follows
  task automatic send_sample(sample_t s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= s;
    do @(posedge clk); while (!s_tready);
    pending_verdicts.push_back(grade_sample(s));
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; cfg_valid stays high until the caller lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ALC_BASE:   alc_base = data;
      CFG_AIR_BASE:   air_base = data;
      CFG_TEMP_BASE:  temp_base = data[TEMP_W-1:0];
      CFG_BASE_VALID: base_on = data[0];
      CFG_RISE_RUNS:  rise_need = data[RUN_W-1:0];
      CFG_FALL_RUNS:  fall_need = data[RUN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(int alc, int air, int tbase, logic valid, int rise, int fall);
    write_reg(CFG_ALC_BASE, CFG_DATA_W'(alc));
    write_reg(CFG_AIR_BASE, CFG_DATA_W'(air));
    write_reg(CFG_TEMP_BASE, CFG_DATA_W'(tbase));
    write_reg(CFG_BASE_VALID, CFG_DATA_W'(valid));
    write_reg(CFG_RISE_RUNS, CFG_DATA_W'(rise));
    write_reg(CFG_FALL_RUNS, CFG_DATA_W'(fall));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // episodes of steady levels around the baseline, with some noise samples
  task automatic run_episodes(int count);
    int sent, len, jit, alc_lvl, air_lvl, temp_lvl, hum_lvl, i;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 7) == 0) begin
        send_sample(make_sample($urandom_range(0, GAS_MAX), $urandom_range(0, GAS_MAX),
                                int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN,
                                $urandom_range(0, HUM_MAX)));
        sent++;
      end else begin
        alc_lvl = int'(alc_base) + tier_offset(ALC_T1, ALC_T2, ALC_T3);
        air_lvl = int'(air_base) + tier_offset(AIR_T1, AIR_T2, AIR_T2);
        case ($urandom_range(0, 5))
          0: temp_lvl = int'(temp_base);
          1: temp_lvl = int'(temp_base) + DRIFT_LIMIT;
          2: temp_lvl = int'(temp_base) + DRIFT_LIMIT + 1;
          3: temp_lvl = int'(temp_base) - DRIFT_LIMIT - 1;
          4: temp_lvl = TEMP_LIMIT + int'($urandom_range(0, 1));
          default: temp_lvl = int'(temp_base) + wobble(200);
        endcase
        case ($urandom_range(0, 3))
          0: hum_lvl = HUM_LIMIT;
          1: hum_lvl = HUM_LIMIT + 1;
          default: hum_lvl = $urandom_range(0, HUM_MAX);
        endcase
        jit = ($urandom_range(0, 1) == 0) ? 0 : 20;
        len = $urandom_range(1, 20);
        for (i = 0; i < len; i++)
          send_sample(make_sample(clamp_int(alc_lvl + wobble(jit), 0, GAS_MAX),
                                  clamp_int(air_lvl + wobble(jit), 0, GAS_MAX),
                                  clamp_int(temp_lvl + wobble(jit), TEMP_MIN, TEMP_MAX),
                                  clamp_int(hum_lvl + wobble(jit), 0, HUM_MAX)));
        sent += len;
      end
    end
  endtask

  // no baseline yet: output stays zero whatever the sample
  task automatic test_uncalibrated();
    send_sample(make_sample(GAS_MAX, GAS_MAX, TEMP_MAX, HUM_MAX));
    send_sample(make_sample(0, 0, TEMP_MIN, 0));
    send_sample(make_sample(20000, 300, 251, 851));
    wait_idle();
  endtask

  // field extremes; verdict reads uncalibrated until the first rise completes
  task automatic test_extremes();
    program_regs(0, 0, TEMP_MIN, 1'b1, RISE_RESET, FALL_RESET);
    repeat (3) send_sample(make_sample(GAS_MAX, GAS_MAX, TEMP_MAX, HUM_MAX));
    repeat (2) send_sample(make_sample(0, 0, TEMP_MIN, 0));
    wait_idle();
  endtask

  // run registers at zero act like one: changes are immediate
  task automatic test_zero_runs();
    program_regs(GAS_MAX, GAS_MAX, TEMP_MAX, 1'b1, 0, 0);
    repeat (2) send_sample(make_sample(0, 0, TEMP_MIN, 0));
    send_sample(make_sample(GAS_MAX, GAS_MAX, TEMP_MAX, HUM_MAX));
    wait_idle();
  endtask

  // writes past the register list change nothing
  task automatic test_spare_index();
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h1234);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_sample(make_sample(GAS_MAX, 0, 0, 500));
    send_sample(make_sample(0, GAS_MAX, 0, 500));
    wait_idle();
  endtask

  // rise after three runs, fall after five, plus humidity and temperature edges
  task automatic test_hysteresis();
    program_regs(1000, 1000, 200, 1'b1, RISE_RESET, FALL_RESET);
    repeat (4) send_sample(make_sample(3000, 2000, 200, 500));
    repeat (6) send_sample(make_sample(1000, 1000, 200, 500));
    send_sample(make_sample(1000, 1000, TEMP_LIMIT + 1, HUM_LIMIT + 1));
    send_sample(make_sample(1000, 1000, TEMP_LIMIT, HUM_LIMIT));
    wait_idle();
  endtask

  // receiver holds off long enough for the input side to stall
  task automatic test_backpressure();
    program_regs(5000, 5000, 200, 1'b1, 2, 4);
    hold_request = 60;
    run_episodes(30);
    wait_idle();
  endtask

  // random settings per phase, extremes in the first two
  task automatic test_random_phases();
    int p;
    for (p = 0; p < 10; p++) begin
      idle_on <= ($urandom_range(0, 3) != 0);
      if (p == 0)
        program_regs(GAS_MAX, GAS_MAX, TEMP_MAX, 1'b1, 15, 15);
      else if (p == 1)
        program_regs(0, 0, TEMP_MIN, 1'b1, 1, 1);
      else
        program_regs(pick_gas_base(), pick_gas_base(), pick_temp_base(),
                     $urandom_range(0, 7) != 0, pick_runs(), pick_runs());
      run_episodes(165);
      wait_idle();
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_steady_stream();
    idle_on <= 1'b0;
    program_regs(pick_gas_base(), pick_gas_base(), pick_temp_base(), 1'b1,
                 pick_runs(), pick_runs());
    run_episodes(150);
    wait_idle();
  endtask

  // long receiver hold, counted here so the sender keeps offering meanwhile
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_active <= 1'b1;
        repeat (hold_request) @(posedge clk);
        hold_active <= 1'b0;
        hold_request = 0;
      end
    end
  end

  // receiver ready with random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (hold_active) begin
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    verdict_rec_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = verdict_rec_t'(m_tdata);
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("unexpected result", int'(m_tdata), 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (got.score !== want.score)
          flag_mismatch("score", int'(got.score), int'(want.score));
        if (got.verdict !== want.verdict)
          flag_mismatch("verdict", int'(got.verdict), int'(want.verdict));
        if (got.drift !== want.drift)
          flag_mismatch("drift_warning", int'(got.drift), int'(want.drift));
        if (got.pad !== want.pad)
          flag_mismatch("padding bit", int'(got.pad), int'(want.pad));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gas_spoilage_verdict_hysteresis test failed");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_uncalibrated();
    test_extremes();
    test_zero_runs();
    test_spare_index();
    test_hysteresis();
    test_backpressure();
    test_random_phases();
    test_steady_stream();
    if (mismatch_count == 0)
      $display("gas_spoilage_verdict_hysteresis test passed");
    else
      $display("gas_spoilage_verdict_hysteresis test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/gsv_pkg.sv
rtl/core/gsv_ram.sv
rtl/core/gsv_ring.sv
rtl/core/gsv_judge.sv
rtl/core/gas_spoilage_verdict_hysteresis.sv
tb/tb.sv
